// File: design/rvcc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rvcc_pkg;

	// Item field widths
	localparam int MV_W       = 16;
	localparam int REG_W      = 8;
	localparam int CODE_W     = 8;
	localparam int SHIFT_W    = 3;
	localparam int STEP_W     = 16;
	localparam int PROD_W     = CODE_W + STEP_W;

	// Segment register packing
	localparam int SEG_W        = 49;
	localparam int SEG_MIN_LSB  = 0;
	localparam int SEG_MAX_LSB  = 16;
	localparam int SEG_STEP_LSB = 32;
	localparam int SEG_INV_BIT  = 48;
	localparam int SEG_SLOTS    = 4;
	localparam int SEG_IDX_W    = 2;
	// segment walk index, holds SEG_SLOTS itself
	localparam int IDX_W        = 3;

	// APB port: 64-bit registers on 8-byte boundaries
	localparam int APB_ADDR_W  = 6;
	localparam int APB_DATA_W  = 64;
	localparam int CFG_IDX_LSB = 3;

	typedef enum logic [2:0] {
		CFG_RAIL_MIN,
		CFG_RAIL_MAX,
		CFG_FIELD_MASK,
		CFG_FIELD_SHIFT,
		CFG_SEG_A,
		CFG_SEG_B,
		CFG_SEG_C,
		CFG_SEG_D
	} cfg_reg_t;

	typedef enum logic {
		OP_ENCODE = 1'b0,
		OP_DECODE = 1'b1
	} op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PREP,
		S_LOAD,
		S_NEXT,
		S_DIV,
		S_POST,
		S_MUL,
		S_SUM,
		S_FINISH
	} state_t;

endpackage
`default_nettype wire

// File: design/rvcc_if.sv
`timescale 1ns / 1ps
`default_nettype none

// request channel: one conversion item
interface rvcc_req_if;
	logic                       valid;
	logic                       ready;
	logic                       opcode;
	logic [rvcc_pkg::MV_W-1:0]  millivolts_in;
	logic [rvcc_pkg::REG_W-1:0] register_in;

	modport source (output valid, opcode, millivolts_in, register_in, input ready);
	modport sink   (input valid, opcode, millivolts_in, register_in, output ready);
endinterface

// response channel: one result item
interface rvcc_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [rvcc_pkg::REG_W-1:0] register_out;
	logic [rvcc_pkg::MV_W-1:0]  millivolts_out;
	logic                       write_needed;
	logic                       code_error;

	modport source (output valid, register_out, millivolts_out, write_needed, code_error,
		input ready);
	modport sink   (input valid, register_out, millivolts_out, write_needed, code_error,
		output ready);
endinterface
`default_nettype wire

// File: design/rail_voltage_code_converter.sv
// Rail voltage code converter. Each req item either encodes a voltage in millivolts into
// the regulator code field of a register byte (opcode 0) or decodes that field back to
// millivolts (opcode 1); each gives exactly one rsp item. The rail range, field mask and
// shift and up to four linear segments are APB registers at byte address 8*i, 64 bits
// wide; write them only while no item is in flight. The segment table is walked one
// segment at a time, and every segment runs a division by its step through one shared
// restoring divider that makes one quotient bit per cycle. An encode that leaves the byte
// alone skips the segment walk. req.ready is high only while the converter is idle; a
// finished result sits in an output register, so the next item can be taken while the
// previous result is still waiting.
`timescale 1ns / 1ps
`default_nettype none
module rail_voltage_code_converter #(
	parameter int SEGMENT_COUNT = 4,
	parameter int VOLT_BITS     = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	rvcc_req_if.sink                            req,
	rvcc_rsp_if.source                          rsp,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [rvcc_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [rvcc_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [rvcc_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready
);

	localparam int VB     = VOLT_BITS;
	localparam int CNT_W  = $clog2(VOLT_BITS);
	localparam int IW     = rvcc_pkg::IDX_W;
	localparam int MW     = rvcc_pkg::MV_W;
	localparam int RW     = rvcc_pkg::REG_W;
	localparam int SW     = rvcc_pkg::STEP_W;
	localparam int PW     = rvcc_pkg::PROD_W;
	localparam int DW     = rvcc_pkg::APB_DATA_W;
	localparam logic [IW-1:0] SEG_LIMIT = IW'(SEGMENT_COUNT);
	localparam logic [VB-1:0] VMAX      = '1;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [MW-1:0]                  rail_min_q;
	logic [MW-1:0]                  rail_max_q;
	logic [RW-1:0]                  field_mask_q;
	logic [rvcc_pkg::SHIFT_W-1:0]   field_shift_q;
	logic [rvcc_pkg::SEG_W-1:0]     seg_q [rvcc_pkg::SEG_SLOTS];
	logic                           cfg_wr;
	rvcc_pkg::cfg_reg_t             cfg_sel;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign cfg_sel = rvcc_pkg::cfg_reg_t'(paddr[rvcc_pkg::APB_ADDR_W-1:rvcc_pkg::CFG_IDX_LSB]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rail_min_q    <= '0;
			rail_max_q    <= '0;
			field_mask_q  <= '0;
			field_shift_q <= '0;
			for (int k = 0; k < rvcc_pkg::SEG_SLOTS; k++) begin
				seg_q[k] <= '0;
			end
		end else if (cfg_wr) begin
			unique case (cfg_sel)
				rvcc_pkg::CFG_RAIL_MIN:    rail_min_q    <= pwdata[MW-1:0];
				rvcc_pkg::CFG_RAIL_MAX:    rail_max_q    <= pwdata[MW-1:0];
				rvcc_pkg::CFG_FIELD_MASK:  field_mask_q  <= pwdata[RW-1:0];
				rvcc_pkg::CFG_FIELD_SHIFT: field_shift_q <= pwdata[rvcc_pkg::SHIFT_W-1:0];
				rvcc_pkg::CFG_SEG_A:       seg_q[0]      <= pwdata[rvcc_pkg::SEG_W-1:0];
				rvcc_pkg::CFG_SEG_B:       seg_q[1]      <= pwdata[rvcc_pkg::SEG_W-1:0];
				rvcc_pkg::CFG_SEG_C:       seg_q[2]      <= pwdata[rvcc_pkg::SEG_W-1:0];
				rvcc_pkg::CFG_SEG_D:       seg_q[3]      <= pwdata[rvcc_pkg::SEG_W-1:0];
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (cfg_sel)
			rvcc_pkg::CFG_RAIL_MIN:    prdata = DW'(rail_min_q);
			rvcc_pkg::CFG_RAIL_MAX:    prdata = DW'(rail_max_q);
			rvcc_pkg::CFG_FIELD_MASK:  prdata = DW'(field_mask_q);
			rvcc_pkg::CFG_FIELD_SHIFT: prdata = DW'(field_shift_q);
			rvcc_pkg::CFG_SEG_A:       prdata = DW'(seg_q[0]);
			rvcc_pkg::CFG_SEG_B:       prdata = DW'(seg_q[1]);
			rvcc_pkg::CFG_SEG_C:       prdata = DW'(seg_q[2]);
			rvcc_pkg::CFG_SEG_D:       prdata = DW'(seg_q[3]);
		endcase
	end

	// ------------------------------------------------------------------
	// Working registers
	// ------------------------------------------------------------------
	rvcc_pkg::state_t      state_q, state_d;
	rvcc_pkg::op_t         op_q;
	logic [VB-1:0]         mv_q;
	logic [RW-1:0]         regin_q;
	logic [RW-1:0]         merged_q;
	logic [rvcc_pkg::CODE_W-1:0] code_q, base_q, top_q, bottom_q, diff_q;
	logic [IW-1:0]         idx_q;
	logic [VB-1:0]         cur_min_q, cur_max_q;
	logic [SW-1:0]         cur_step_q;
	logic                  cur_inv_q;
	logic                  final_q;
	logic [SW-1:0]         rem_q;
	logic [VB-1:0]         quo_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [PW-1:0]         prod_q;
	logic [RW-1:0]         res_reg_q;
	logic [MW-1:0]         res_mv_q;
	logic                  res_wn_q, res_err_q;
	logic                  rsp_valid_q;
	logic [RW-1:0]         rsp_reg_q;
	logic [MW-1:0]         rsp_mv_q;
	logic                  rsp_wn_q, rsp_err_q;

	// ------------------------------------------------------------------
	// Segment table read port (one address per cycle)
	// ------------------------------------------------------------------
	logic [IW-1:0]              rd_idx;
	logic [rvcc_pkg::SEG_W-1:0] seg_rd;
	logic [VB-1:0]              rd_min, rd_max;
	logic [SW-1:0]              rd_step;
	logic                       rd_inv;
	logic                       rd_live;

	// look one segment ahead while snapping a voltage in a gap
	assign rd_idx  = (state_q == rvcc_pkg::S_NEXT) ? idx_q + IW'(1) : idx_q;
	assign seg_rd  = seg_q[rd_idx[rvcc_pkg::SEG_IDX_W-1:0]];
	assign rd_min  = seg_rd[rvcc_pkg::SEG_MIN_LSB +: VB];
	assign rd_max  = seg_rd[rvcc_pkg::SEG_MAX_LSB +: VB];
	assign rd_step = seg_rd[rvcc_pkg::SEG_STEP_LSB +: SW];
	assign rd_inv  = seg_rd[rvcc_pkg::SEG_INV_BIT];
	assign rd_live = (rd_idx < SEG_LIMIT) && (rd_max != '0);

	// ------------------------------------------------------------------
	// Clamp, snap and dividend selection
	// ------------------------------------------------------------------
	logic [VB-1:0] rmin, rmax, mv_clamp, next_min, mv_eff, sub_a, sub_b, dividend;
	logic          skip_enc, in_seg;

	assign rmin     = rail_min_q[VB-1:0];
	assign rmax     = rail_max_q[VB-1:0];
	assign skip_enc = (mv_q == '0) || (rmin == '0);
	assign mv_clamp = (mv_q < rmin) ? rmin : ((mv_q > rmax) ? rmax : mv_q);

	assign next_min = rd_live ? rd_min : '0;
	assign mv_eff   = (mv_q > cur_max_q && mv_q < next_min) ? cur_max_q : mv_q;
	assign in_seg   = cur_max_q >= mv_eff;

	// one saturating subtract: segment span, or offset into the segment
	assign sub_a    = (state_q == rvcc_pkg::S_NEXT) ? (in_seg ? mv_eff : cur_max_q) : rd_max;
	assign sub_b    = (state_q == rvcc_pkg::S_NEXT) ? cur_min_q : rd_min;
	assign dividend = (sub_a >= sub_b) ? sub_a - sub_b : '0;

	// ------------------------------------------------------------------
	// Restoring divider step: one quotient bit per cycle
	// ------------------------------------------------------------------
	logic [SW:0]   trial, trial_sub;
	logic          div_ge;
	logic [SW-1:0] rem_d;
	logic [VB-1:0] quo_d;

	assign trial     = {rem_q, quo_q[VB-1]};
	assign div_ge    = trial >= {1'b0, cur_step_q};
	assign trial_sub = trial - {1'b0, cur_step_q};
	assign rem_d     = div_ge ? trial_sub[SW-1:0] : trial[SW-1:0];
	assign quo_d     = {quo_q[VB-2:0], div_ge};

	// ------------------------------------------------------------------
	// Quotient use: code merge, code counting, final sum
	// ------------------------------------------------------------------
	logic [rvcc_pkg::CODE_W-1:0] q8, top_new, code_enc;
	logic [RW-1:0]               field_raw, field;
	logic                        dec_hit;
	logic [PW:0]                 sum_w;
	logic                        sum_sat;

	assign q8        = quo_q[rvcc_pkg::CODE_W-1:0];
	assign top_new   = top_q + q8 + rvcc_pkg::CODE_W'(1);
	assign dec_hit   = code_q < top_new;
	assign code_enc  = base_q + q8;
	assign field_raw = (code_enc << field_shift_q) & field_mask_q;
	assign field     = cur_inv_q ? (~field_raw & field_mask_q) : field_raw;
	assign sum_w     = {1'b0, prod_q} + (PW + 1)'(cur_min_q);
	assign sum_sat   = sum_w > (PW + 1)'(VMAX);

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	logic out_free;
	assign out_free = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rvcc_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		unique case (state_q)
			rvcc_pkg::S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) state_d = rvcc_pkg::S_PREP;
			end
			rvcc_pkg::S_PREP: begin
				if (op_q == rvcc_pkg::OP_ENCODE && skip_enc) state_d = rvcc_pkg::S_FINISH;
				else state_d = rvcc_pkg::S_LOAD;
			end
			rvcc_pkg::S_LOAD: begin
				if (!rd_live || rd_step == '0) state_d = rvcc_pkg::S_FINISH;
				else if (op_q == rvcc_pkg::OP_ENCODE) state_d = rvcc_pkg::S_NEXT;
				else state_d = rvcc_pkg::S_DIV;
			end
			rvcc_pkg::S_NEXT: state_d = rvcc_pkg::S_DIV;
			rvcc_pkg::S_DIV: begin
				if (cnt_q == '0) state_d = rvcc_pkg::S_POST;
			end
			rvcc_pkg::S_POST: begin
				if (op_q == rvcc_pkg::OP_ENCODE) begin
					state_d = final_q ? rvcc_pkg::S_FINISH : rvcc_pkg::S_LOAD;
				end else begin
					state_d = dec_hit ? rvcc_pkg::S_MUL : rvcc_pkg::S_LOAD;
				end
			end
			rvcc_pkg::S_MUL:    state_d = rvcc_pkg::S_SUM;
			rvcc_pkg::S_SUM:    state_d = rvcc_pkg::S_FINISH;
			rvcc_pkg::S_FINISH: begin
				if (out_free) state_d = rvcc_pkg::S_IDLE;
			end
			default:            state_d = rvcc_pkg::S_IDLE;
		endcase
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			rvcc_pkg::S_IDLE: begin
				if (req.valid) begin
					op_q    <= rvcc_pkg::op_t'(req.opcode);
					mv_q    <= req.millivolts_in[VB-1:0];
					regin_q <= req.register_in;
				end
			end
			rvcc_pkg::S_PREP: begin
				mv_q      <= mv_clamp;
				code_q    <= (regin_q & field_mask_q) >> field_shift_q;
				merged_q  <= regin_q & ~field_mask_q;
				base_q    <= '0;
				top_q     <= '0;
				bottom_q  <= '0;
				idx_q     <= '0;
				res_reg_q <= regin_q;
				res_mv_q  <= '0;
				res_wn_q  <= 1'b0;
				res_err_q <= 1'b0;
			end
			rvcc_pkg::S_LOAD: begin
				cur_min_q  <= rd_min;
				cur_max_q  <= rd_max;
				cur_step_q <= rd_step;
				cur_inv_q  <= rd_inv;
				// decode starts on the span right away
				rem_q      <= '0;
				quo_q      <= dividend;
				cnt_q      <= CNT_W'(VB - 1);
				if (!rd_live) begin
					// ran off the table
					if (op_q == rvcc_pkg::OP_ENCODE) begin
						res_reg_q <= merged_q;
						res_wn_q  <= 1'b1;
					end else begin
						res_err_q <= 1'b1;
					end
				end else if (rd_step == '0) begin
					res_err_q <= 1'b1;
				end
			end
			rvcc_pkg::S_NEXT: begin
				mv_q    <= mv_eff;
				final_q <= in_seg;
				rem_q   <= '0;
				quo_q   <= dividend;
				cnt_q   <= CNT_W'(VB - 1);
			end
			rvcc_pkg::S_DIV: begin
				rem_q <= rem_d;
				quo_q <= quo_d;
				cnt_q <= cnt_q - CNT_W'(1);
			end
			rvcc_pkg::S_POST: begin
				if (op_q == rvcc_pkg::OP_ENCODE) begin
					if (final_q) begin
						res_reg_q <= merged_q | field;
						res_wn_q  <= 1'b1;
					end else begin
						base_q <= base_q + q8 + rvcc_pkg::CODE_W'(1);
						idx_q  <= idx_q + IW'(1);
					end
				end else begin
					if (dec_hit) begin
						diff_q <= (code_q >= bottom_q) ? code_q - bottom_q : '0;
					end else begin
						top_q    <= top_new;
						bottom_q <= top_new;
						idx_q    <= idx_q + IW'(1);
					end
				end
			end
			rvcc_pkg::S_MUL: begin
				prod_q <= diff_q * cur_step_q;
			end
			rvcc_pkg::S_SUM: begin
				res_mv_q <= sum_sat ? MW'(VMAX) : MW'(sum_w[VB-1:0]);
			end
			rvcc_pkg::S_FINISH: begin
			end
			default: begin
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == rvcc_pkg::S_FINISH && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == rvcc_pkg::S_FINISH && out_free) begin
			rsp_reg_q <= res_reg_q;
			rsp_mv_q  <= res_mv_q;
			rsp_wn_q  <= res_wn_q;
			rsp_err_q <= res_err_q;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.register_out   = rsp_reg_q;
	assign rsp.millivolts_out = rsp_mv_q;
	assign rsp.write_needed   = rsp_wn_q;
	assign rsp.code_error     = rsp_err_q;

endmodule
`default_nettype wire

// File: design/rvcc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module rvcc_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       req_valid,
	input logic                       req_ready,
	input logic                       rsp_valid,
	input logic                       rsp_ready,
	input logic [rvcc_pkg::REG_W-1:0] rsp_register_out,
	input logic [rvcc_pkg::MV_W-1:0]  rsp_millivolts_out,
	input logic                       rsp_write_needed,
	input logic                       rsp_code_error
);

	// one item at a time: busy right after taking an item
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("converter took an item while still working");

	// a stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_register_out)
			&& $stable(rsp_millivolts_out) && $stable(rsp_write_needed)
			&& $stable(rsp_code_error))
		else $error("result changed or dropped while stalled");

	// a write is never asked for together with an error
	a_wn_err_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp_write_needed && rsp_code_error))
		else $error("write_needed and code_error both set");

	// a decoded voltage only comes from a clean decode
	a_mv_decode_only: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_millivolts_out != '0 |-> !rsp_write_needed && !rsp_code_error)
		else $error("voltage reported on an encode or error result");

endmodule

bind rail_voltage_code_converter rvcc_checker u_rvcc_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.req_valid          (req.valid),
	.req_ready          (req.ready),
	.rsp_valid          (rsp.valid),
	.rsp_ready          (rsp.ready),
	.rsp_register_out   (rsp.register_out),
	.rsp_millivolts_out (rsp.millivolts_out),
	.rsp_write_needed   (rsp.write_needed),
	.rsp_code_error     (rsp.code_error)
);
`default_nettype wire

// File: test/rail_voltage_code_converter_tb.sv
`timescale 1ns / 1ps
module rail_voltage_code_converter_tb;
	import rvcc_pkg::*;

	localparam int SEGS           = 4;
	localparam int RAND_PHASES    = 30;
	localparam int PHASE_ITEMS    = 62;
	localparam int RX_HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES  = 8;
	localparam int END_CYCLES     = 100;

	// kinds of register setting for the random part
	localparam int STYLE_TABLE = 0;
	localparam int STYLE_WILD  = 1;
	localparam int STYLE_EDGE  = 2;

	typedef struct {
		op_t         op;
		logic [15:0] mv;
		logic [7:0]  rb;
	} conv_item_t;

	typedef struct packed {
		logic [7:0]  reg_byte;
		logic [15:0] millivolts_out;
		logic        write_needed;
		logic        code_error;
	} conv_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;

	rvcc_req_if req ();
	rvcc_rsp_if rsp ();

	rail_voltage_code_converter dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #10 clk = ~clk;

	// shadow of the converter's registers
	logic [15:0] m_rail_min;
	logic [15:0] m_rail_max;
	logic [7:0]  m_mask;
	logic [2:0]  m_shift;
	logic [15:0] m_seg_lo[SEGS];
	logic [15:0] m_seg_hi[SEGS];
	logic [15:0] m_seg_step[SEGS];
	logic        m_seg_inv[SEGS];

	logic [63:0] next_cfg[8];
	int          tbl_lo;
	int          tbl_hi;

	conv_item_t   req_backlog[$];
	conv_result_t predicted_q[$];
	conv_item_t   drv_item;
	conv_result_t want;

	int tx_idle_pct;
	int rx_idle_pct;
	bit tx_pause;
	bit hold_go;
	int hold_left;

	int items_sent;
	int fails;
	int n_encode;
	int n_decode;
	int n_writes;
	int n_errors;
	int n_settings;
	int edge_turn;

	function automatic bit seg_live(input int i);
		return (i < SEGS) && (m_seg_hi[i] != 0);
	endfunction

	// codes covered by one segment, modulo 256; step is nonzero here
	function automatic int unsigned codes_in_seg(input int i);
		int unsigned lo, hi, st, span;
		lo = m_seg_lo[i];
		hi = m_seg_hi[i];
		st = m_seg_step[i];
		span = (hi >= lo) ? hi - lo : 0;
		return ((span + st) / st) & 8'hFF;
	endfunction

	// expected result of one conversion under the current registers
	function automatic conv_result_t convert_item(input op_t op, input logic [15:0] mv_in,
			input logic [7:0] rb);
		conv_result_t r;
		int unsigned mv, base, top, bottom, lo, hi, st, nxt, off, code, field, merged, diff, v;
		int i;
		r = '0;
		r.reg_byte = rb;
		if (op == OP_ENCODE) begin
			mv = mv_in;
			if (mv == 0 || m_rail_min == 0)
				return r;
			if (mv < m_rail_min)
				mv = m_rail_min;
			else if (mv > m_rail_max)
				mv = m_rail_max;
			merged = rb & ~{24'd0, m_mask} & 8'hFF;
			base = 0;
			for (i = 0; seg_live(i); i++) begin
				lo = m_seg_lo[i];
				hi = m_seg_hi[i];
				st = m_seg_step[i];
				nxt = seg_live(i + 1) ? m_seg_lo[i + 1] : 0;
				if (st == 0) begin
					r.code_error = 1'b1;
					return r;
				end
				// a voltage in the gap snaps down to this segment's top
				if (mv > hi && mv < nxt)
					mv = hi;
				if (hi >= mv) begin
					off = (mv >= lo) ? (mv - lo) / st : 0;
					code = (base + off) & 24'hFFFFFF;
					field = (code << m_shift) & m_mask;
					if (m_seg_inv[i])
						field = ~field & m_mask;
					merged = merged | field;
					break;
				end
				base = (base + codes_in_seg(i)) & 8'hFF;
			end
			r.reg_byte = merged[7:0];
			r.write_needed = 1'b1;
		end else begin
			code = (rb & m_mask) >> m_shift;
			top = 0;
			bottom = 0;
			for (i = 0; seg_live(i); i++) begin
				st = m_seg_step[i];
				if (st == 0) begin
					r.code_error = 1'b1;
					return r;
				end
				top = (top + codes_in_seg(i)) & 8'hFF;
				if (code < top) begin
					diff = (code >= bottom) ? code - bottom : 0;
					v = diff * st + m_seg_lo[i];
					r.millivolts_out = (v > 16'hFFFF) ? 16'hFFFF : v[15:0];
					return r;
				end
				bottom = top;
			end
			// code beyond the table
			r.code_error = 1'b1;
		end
		return r;
	endfunction

	function automatic logic [63:0] pack_seg(input int unsigned lo, input int unsigned hi,
			input int unsigned st, input bit inv);
		return {15'd0, inv, st[15:0], hi[15:0], lo[15:0]};
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.opcode <= OP_ENCODE;
			req.millivolts_in <= '0;
			req.register_in <= '0;
		end else begin
			if (req.valid && req.ready) begin
				predicted_q.push_back(convert_item(op_t'(req.opcode), req.millivolts_in,
					req.register_in));
				items_sent++;
			end
			if (!req.valid || req.ready) begin
				if (req_backlog.size() != 0 && !tx_pause &&
						$urandom_range(0, 99) >= tx_idle_pct) begin
					drv_item = req_backlog.pop_front();
					req.valid <= 1'b1;
					req.opcode <= drv_item.op;
					req.millivolts_in <= drv_item.mv;
					req.register_in <= drv_item.rb;
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string name, input logic [15:0] exp_v,
			input logic [15:0] act);
		if (act !== exp_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act);
			fails++;
		end
	endtask

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (predicted_q.size() == 0) begin
					$error("result item arrived with nothing outstanding");
					fails++;
				end else begin
					want = predicted_q.pop_front();
					check_field("register_out", want.reg_byte, rsp.register_out);
					check_field("millivolts_out", want.millivolts_out, rsp.millivolts_out);
					check_field("write_needed", want.write_needed, rsp.write_needed);
					check_field("code_error", want.code_error, rsp.code_error);
					if (want.write_needed)
						n_writes++;
					if (want.code_error)
						n_errors++;
				end
			end
			rsp.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	// long receiver stall, counted here
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hold_left <= 0;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
		else if (hold_go)
			hold_left <= RX_HOLD_CYCLES;
	end

	task automatic apb_write(input cfg_reg_t idx, input logic [63:0] val);
		logic [APB_ADDR_W-1:0] a;
		int s;
		a = idx;
		a = a << CFG_IDX_LSB;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= a;
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			CFG_RAIL_MIN: m_rail_min = val[15:0];
			CFG_RAIL_MAX: m_rail_max = val[15:0];
			CFG_FIELD_MASK: m_mask = val[7:0];
			CFG_FIELD_SHIFT: m_shift = val[2:0];
			default: begin
				s = int'(idx) - int'(CFG_SEG_A);
				m_seg_lo[s] = val[15:0];
				m_seg_hi[s] = val[31:16];
				m_seg_step[s] = val[47:32];
				m_seg_inv[s] = val[48];
			end
		endcase
	endtask

	task automatic program_setting();
		int k;
		for (k = 0; k < 8; k++)
			apb_write(cfg_reg_t'(k), next_cfg[k]);
		n_settings++;
	endtask

	task automatic roll_setting(input int style);
		int i, n, cur, lo, hi, st, cnt, w, first_lo, last_hi, rmin, rmax;
		bit inv;
		case (style)
			STYLE_TABLE: begin
				n = $urandom_range(1, SEGS);
				cur = $urandom_range(200, 3000);
				first_lo = cur;
				last_hi = cur;
				for (i = 0; i < SEGS; i++) begin
					if (i < n) begin
						case ($urandom_range(0, 3))
							0: st = 10;
							1: st = 25;
							2: st = 50;
							default: st = $urandom_range(1, 300);
						endcase
						cnt = $urandom_range(1, 48);
						lo = cur;
						hi = lo + st * (cnt - 1);
						// now and then a segment whose max sits below its min
						if ($urandom_range(0, 15) == 0)
							hi = lo - $urandom_range(1, 100);
						if (hi > 65535)
							hi = 65535;
						inv = ($urandom_range(0, 7) == 0);
						last_hi = (hi > lo) ? hi : lo;
						cur = last_hi + $urandom_range(1, 4 * st + 20);
						if (cur > 65000)
							cur = 65000;
						if ($urandom_range(0, 19) == 0)
							st = 0;
						next_cfg[int'(CFG_SEG_A) + i] = pack_seg(lo, hi, st, inv);
					end else if (i == n) begin
						// max of zero ends the table, other fields are noise
						next_cfg[int'(CFG_SEG_A) + i] = pack_seg($urandom, 0, $urandom,
							$urandom_range(0, 1));
					end else begin
						next_cfg[int'(CFG_SEG_A) + i] = {$urandom, $urandom};
					end
				end
				rmax = last_hi + $urandom_range(0, 300) - 150;
				if (rmax < 1)
					rmax = 1;
				if (rmax > 65535)
					rmax = 65535;
				case ($urandom_range(0, 9))
					0: rmin = 0;
					1: begin
						rmin = rmax + $urandom_range(1, 500);
						if (rmin > 65535)
							rmin = 65535;
					end
					default: rmin = $urandom_range(1, first_lo + 50);
				endcase
				next_cfg[CFG_RAIL_MIN] = rmin;
				next_cfg[CFG_RAIL_MAX] = rmax;
				next_cfg[CFG_FIELD_SHIFT] = $urandom_range(0, 7);
				w = $urandom_range(1, 8);
				next_cfg[CFG_FIELD_MASK] = (((1 << w) - 1) << next_cfg[CFG_FIELD_SHIFT]) & 8'hFF;
				if ($urandom_range(0, 6) == 0)
					next_cfg[CFG_FIELD_MASK] = $urandom_range(0, 255);
				tbl_lo = (first_lo > 100) ? first_lo - 100 : 0;
				tbl_hi = (last_hi < 65435) ? last_hi + 100 : 65535;
			end
			STYLE_WILD: begin
				for (i = 0; i < 8; i++)
					next_cfg[i] = {$urandom, $urandom};
				tbl_lo = 0;
				tbl_hi = 65535;
			end
			default: begin
				for (i = 0; i < 8; i++)
					next_cfg[i] = '0;
				case (edge_turn % 3)
					0: ;
					1: begin
						for (i = 0; i < 8; i++)
							next_cfg[i] = '1;
					end
					default: begin
						next_cfg[CFG_RAIL_MIN] = 1;
						next_cfg[CFG_RAIL_MAX] = 65535;
						next_cfg[CFG_FIELD_MASK] = 8'hFF;
						next_cfg[CFG_SEG_A] = pack_seg(1, 65535, 1, 1'b0);
						next_cfg[CFG_SEG_B] = pack_seg(0, 65535, 65535, 1'b1);
						next_cfg[CFG_SEG_C] = pack_seg(65535, 65535, 1, 1'b0);
					end
				endcase
				edge_turn++;
				tbl_lo = 0;
				tbl_hi = 65535;
			end
		endcase
	endtask

	task automatic push_item(input op_t op, input int mv, input int rb);
		conv_item_t it;
		it.op = op;
		it.mv = mv;
		it.rb = rb;
		req_backlog.push_back(it);
		if (op == OP_ENCODE)
			n_encode++;
		else
			n_decode++;
	endtask

	task automatic queue_random_items(input int n);
		int k, mv;
		op_t op;
		for (k = 0; k < n; k++) begin
			op = ($urandom_range(0, 1) != 0) ? OP_DECODE : OP_ENCODE;
			case ($urandom_range(0, 9))
				0: mv = 0;
				1, 2: mv = $urandom_range(0, 65535);
				default: mv = $urandom_range(tbl_lo, tbl_hi);
			endcase
			push_item(op, mv, $urandom_range(0, 255));
		end
	endtask

	// wait until nothing is queued, offered or outstanding
	task automatic drain();
		do @(negedge clk);
		while (req_backlog.size() != 0 || req.valid || predicted_q.size() != 0);
	endtask

	task automatic start_rx_hold();
		@(negedge clk);
		hold_go = 1'b1;
		do @(negedge clk); while (hold_left == 0);
		hold_go = 1'b0;
	endtask

	task automatic set_idle(input int tx_pct, input int rx_pct);
		@(negedge clk);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
	endtask

	initial begin
		#25_000_000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		int p, style, sent_mark;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req.valid = 1'b0;
		req.opcode = OP_ENCODE;
		req.millivolts_in = '0;
		req.register_in = '0;
		rsp.ready = 1'b0;
		tx_idle_pct = 26;
		rx_idle_pct = 54;
		tx_pause = 1'b0;
		hold_go = 1'b0;
		items_sent = 0;
		fails = 0;
		n_encode = 0;
		n_decode = 0;
		n_writes = 0;
		n_errors = 0;
		n_settings = 0;
		edge_turn = 0;
		m_rail_min = '0;
		m_rail_max = '0;
		m_mask = '0;
		m_shift = '0;
		for (p = 0; p < SEGS; p++) begin
			m_seg_lo[p] = '0;
			m_seg_hi[p] = '0;
			m_seg_step[p] = '0;
			m_seg_inv[p] = 1'b0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// two segments with a gap, the second inverted, then end of table
		next_cfg[CFG_RAIL_MIN] = 600;
		next_cfg[CFG_RAIL_MAX] = 1500;
		next_cfg[CFG_FIELD_MASK] = 8'h3C;
		next_cfg[CFG_FIELD_SHIFT] = 2;
		next_cfg[CFG_SEG_A] = pack_seg(600, 1000, 50, 1'b0);
		next_cfg[CFG_SEG_B] = pack_seg(1100, 1400, 100, 1'b1);
		next_cfg[CFG_SEG_C] = pack_seg(1234, 0, 7, 1'b1);
		next_cfg[CFG_SEG_D] = '1;
		program_setting();
		push_item(OP_ENCODE, 0, 8'hA5);
		push_item(OP_ENCODE, 100, 8'hFF);
		push_item(OP_ENCODE, 65535, 8'h00);
		push_item(OP_ENCODE, 1050, 8'hC3);
		push_item(OP_ENCODE, 1250, 8'h00);
		push_item(OP_ENCODE, 620, 8'hFF);
		push_item(OP_ENCODE, 999, 8'h5A);
		push_item(OP_DECODE, 0, 8'h00);
		push_item(OP_DECODE, 0, 8'h20);
		push_item(OP_DECODE, 0, 8'h24);
		push_item(OP_DECODE, 0, 8'h30);
		push_item(OP_DECODE, 0, 8'h34);
		push_item(OP_DECODE, 65535, 8'hFF);
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);

		// all clear: encoding disabled, empty table
		for (p = 0; p < 8; p++)
			next_cfg[p] = '0;
		program_setting();
		push_item(OP_ENCODE, 1234, 8'h5A);
		push_item(OP_DECODE, 1234, 8'h5A);
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);

		// min above max, full-width segment, segment with max below min
		next_cfg[CFG_RAIL_MIN] = 16'hFFFF;
		next_cfg[CFG_RAIL_MAX] = 0;
		next_cfg[CFG_FIELD_MASK] = 8'hFF;
		next_cfg[CFG_FIELD_SHIFT] = 7;
		next_cfg[CFG_SEG_A] = pack_seg(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
		next_cfg[CFG_SEG_B] = pack_seg(900, 800, 10, 1'b0);
		next_cfg[CFG_SEG_C] = pack_seg(1, 2, 0, 1'b0);
		next_cfg[CFG_SEG_D] = '1;
		program_setting();
		push_item(OP_ENCODE, 1, 8'h00);
		push_item(OP_ENCODE, 16'hFFFF, 8'h5A);
		push_item(OP_DECODE, 0, 8'h80);
		push_item(OP_DECODE, 0, 8'h7F);
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);

		// zero step in the second segment
		next_cfg[CFG_RAIL_MIN] = 100;
		next_cfg[CFG_RAIL_MAX] = 5000;
		next_cfg[CFG_FIELD_MASK] = 8'h0F;
		next_cfg[CFG_FIELD_SHIFT] = 0;
		next_cfg[CFG_SEG_A] = pack_seg(100, 200, 50, 1'b0);
		next_cfg[CFG_SEG_B] = pack_seg(300, 400, 0, 1'b0);
		next_cfg[CFG_SEG_C] = '0;
		next_cfg[CFG_SEG_D] = '0;
		program_setting();
		push_item(OP_ENCODE, 150, 8'hF0);
		push_item(OP_ENCODE, 350, 8'hF0);
		push_item(OP_DECODE, 0, 8'h02);
		push_item(OP_DECODE, 0, 8'h05);
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);

		// random part: a new setting per phase, three idle profiles in turn
		for (p = 0; p < RAND_PHASES; p++) begin
			if (p % 6 == 5)
				style = STYLE_WILD;
			else if (p % 10 == 7 || p == RAND_PHASES - 1)
				style = STYLE_EDGE;
			else
				style = STYLE_TABLE;
			roll_setting(style);
			program_setting();
			if (p < 10)
				set_idle(26, 54);
			else if (p < 20)
				set_idle(54, 26);
			else
				set_idle(0, 0);
			sent_mark = items_sent;
			queue_random_items(PHASE_ITEMS);
			if (p == 4 || p == 23)
				start_rx_hold();
			if (p == 15) begin
				// sender stops until every result is back
				do @(negedge clk); while (items_sent < sent_mark + PHASE_ITEMS / 2);
				tx_pause = 1'b1;
				@(negedge clk);
				while (req.valid || predicted_q.size() != 0)
					@(negedge clk);
				repeat (20) @(negedge clk);
				tx_pause = 1'b0;
			end
			drain();
			repeat (SETTLE_CYCLES) @(posedge clk);
		end

		repeat (END_CYCLES) @(posedge clk);
		$display("Covered %0d items (%0d encode, %0d decode): %0d byte writes, %0d code errors.",
			items_sent, n_encode, n_decode, n_writes, n_errors);
		$display("Used %0d register settings, three idle profiles, a long output stall "
			, n_settings, "and a sender pause.");
		if (fails == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
